>>> design/pfc_pkg.sv
// pixel format converter package: format codes, register indexes and shared types
// no dependencies; used by every file of the converter but pfc_if
package pfc_pkg;

	// pixel layout codes, as held in the format registers
	localparam logic [2:0] FMT_A8       = 3'd0;
	localparam logic [2:0] FMT_RGB888   = 3'd1;
	localparam logic [2:0] FMT_RGB565   = 3'd2;
	localparam logic [2:0] FMT_RGBA5551 = 3'd3;
	localparam logic [2:0] FMT_RGBA4444 = 3'd4;
	localparam logic [2:0] FMT_RGBA8888 = 3'd5;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_FORMAT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY = 2'd2;

	// queue depth between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// current configuration as seen by front and back
	typedef struct packed {
		logic [2:0] src_format;
		logic [2:0] dst_format;
		logic       premultiply;
	} cfg_t;

	// pixel expanded to rgba8888 (r in the low byte), with its run marker
	typedef struct packed {
		logic [31:0] rgba;
		logic        last;
	} pix_t;

endpackage

>>> design/pfc_if.sv
// stream channels of the pixel format converter: input and output requests
// valid/ready handshake with the pixel word and run marker as payload
interface pfc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_in;
	logic        last_in;

	modport source (output valid, output pixel_in, output last_in, input ready);
	modport sink (input valid, input pixel_in, input last_in, output ready);
endinterface

interface pfc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_out;
	logic        last_out;

	modport source (output valid, output pixel_out, output last_out, input ready);
	modport sink (input valid, input pixel_out, input last_out, output ready);
endinterface

>>> design/pfc_front.sv
// front of the converter: accepts source pixels and expands them to rgba8888
// depends on pfc_pkg and pfc_if
module pfc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  pfc_pkg::cfg_t     cfg,
	pfc_in_if.sink            in_ch,
	output logic              valid_s1,
	output pfc_pkg::pix_t     pix_s1,
	input  logic              take
);

	logic [31:0] p;
	logic [31:0] rgba;
	logic        ready;

	assign p = in_ch.pixel_in;

	// expand source layout to rgba8888, missing alpha is opaque, unknown codes give zero
	always_comb begin
		case (cfg.src_format)
			pfc_pkg::FMT_A8:       rgba = {p[7:0], 24'h000000};
			pfc_pkg::FMT_RGB888:   rgba = {8'hFF, p[23:0]};
			pfc_pkg::FMT_RGB565:   rgba = {8'hFF, p[4:0], 3'b000, p[10:5], 2'b00,
				p[15:11], 3'b000};
			pfc_pkg::FMT_RGBA5551: rgba = {{8{p[15]}}, p[14:10], 3'b000,
				p[9:5], 3'b000, p[4:0], 3'b000};
			pfc_pkg::FMT_RGBA4444: rgba = {p[3:0], 4'h0, p[7:4], 4'h0,
				p[11:8], 4'h0, p[15:12], 4'h0};
			pfc_pkg::FMT_RGBA8888: rgba = p;
			default:               rgba = 32'h0000_0000;
		endcase
	end

	// stage register advances when empty or when the queue takes it
	assign ready = !valid_s1 || take;
	assign in_ch.ready = ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (ready && in_ch.valid) begin
			pix_s1.rgba <= rgba;
			pix_s1.last <= in_ch.last_in;
		end
	end

endmodule

>>> design/pfc_queue.sv
// short fifo between front and back of the converter
// depends on pfc_pkg
module pfc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfc_pkg::pix_t push_data,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output pfc_pkg::pix_t head
);

	localparam int unsigned PTR_W = (pfc_pkg::QUEUE_DEPTH > 1) ?
		$clog2(pfc_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(pfc_pkg::QUEUE_DEPTH + 1);

	pfc_pkg::pix_t      mem_q [pfc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign not_full  = (count_q != CNT_W'(pfc_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	// pointer step with wrap
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(pfc_pkg::QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> design/pfc_back.sv
// back of the converter: packs rgba8888 into the destination layout and premultiplies
// depends on pfc_pkg and pfc_if
module pfc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pfc_pkg::cfg_t cfg,
	input  logic          avail,
	input  pfc_pkg::pix_t head,
	output logic          take,
	pfc_out_if.source     out_ch
);

	logic [31:0] c;
	logic [31:0] packed_pix;
	logic [31:0] result;
	logic        wide;
	logic [7:0]  mul_a;
	logic [7:0]  mul_r;
	logic [7:0]  mul_g;
	logic [7:0]  mul_b;
	logic [15:0] prod_r;
	logic [15:0] prod_g;
	logic [15:0] prod_b;
	logic        out_valid_q;
	logic        load;

	assign c = head.rgba;

	// pack by dropping low channel bits, 5551 alpha bit as OR of the top alpha nibble
	always_comb begin
		case (cfg.dst_format)
			pfc_pkg::FMT_A8:       packed_pix = {24'h000000, c[31:24]};
			pfc_pkg::FMT_RGB888:   packed_pix = {8'h00, c[23:0]};
			pfc_pkg::FMT_RGB565:   packed_pix = {16'h0000, c[7:3], c[15:10], c[23:19]};
			pfc_pkg::FMT_RGBA5551: packed_pix = {16'h0000, |c[31:28], c[23:19],
				c[15:11], c[7:3]};
			pfc_pkg::FMT_RGBA4444: packed_pix = {16'h0000, c[7:4], c[15:12],
				c[23:20], c[31:28]};
			pfc_pkg::FMT_RGBA8888: packed_pix = c;
			default:               packed_pix = 32'h0000_0000;
		endcase
	end

	// channel scaling: full bytes for rgba8888, top nibbles for rgba4444
	assign wide  = (cfg.dst_format == pfc_pkg::FMT_RGBA8888);
	assign mul_a = wide ? c[31:24] : {4'h0, c[31:28]};
	assign mul_r = wide ? c[7:0]   : {4'h0, c[7:4]};
	assign mul_g = wide ? c[15:8]  : {4'h0, c[15:12]};
	assign mul_b = wide ? c[23:16] : {4'h0, c[23:20]};
	assign prod_r = mul_r * mul_a;
	assign prod_g = mul_g * mul_a;
	assign prod_b = mul_b * mul_a;

	// premultiply in destination layout (rgba5551, rgba4444, rgba8888 only), alpha kept
	always_comb begin
		result = packed_pix;
		if (cfg.premultiply) begin
			case (cfg.dst_format)
				pfc_pkg::FMT_RGBA5551: result = packed_pix[15] ? packed_pix : 32'h0000_0000;
				pfc_pkg::FMT_RGBA4444: result = {16'h0000, prod_r[7:4], prod_g[7:4],
					prod_b[7:4], c[31:28]};
				pfc_pkg::FMT_RGBA8888: result = {c[31:24], prod_b[15:8], prod_g[15:8],
					prod_r[15:8]};
				default:               result = packed_pix;
			endcase
		end
	end

	// output register loads when empty or being drained
	assign load = !out_valid_q || out_ch.ready;
	assign take = load && avail;
	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= avail;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_ch.pixel_out <= result;
			out_ch.last_out  <= head.last;
		end
	end

endmodule

>>> design/pixel_format_converter.sv
// pixel format converter top level: configuration registers, front, queue and back
// depends on pfc_pkg, pfc_if, pfc_front, pfc_queue and pfc_back
//
// usage:
//   in_ch takes one source pixel (pixel_in right-aligned, last_in) per ready cycle;
//   out_ch gives one converted pixel request (pixel_out, last_out) for each input,
//   in order. cfg_we/cfg_index/cfg_data write src_format (0), dst_format (1) and
//   premultiply (2); other indexes are ignored. Write only while the block is idle.
// timing:
//   throughput is one pixel per cycle while out_ch.ready stays high; the front and
//   output registers are single stages with a two-entry queue between them; an
//   accepted pixel passes the front register, then queue, then output register.
// reset:
//   arst_n clears all valid state and sets both formats to rgba8888 with
//   premultiply off; no pixels are held afterward.
// stall:
//   when out_ch.ready is low the output register holds, the queue fills and then
//   the front register fills, and in_ch.ready drops; up to four pixels sit inside.
module pixel_format_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data,
	pfc_in_if.sink                            in_ch,
	pfc_out_if.source                         out_ch
);

	pfc_pkg::cfg_t cfg_q;
	logic          valid_s1;
	pfc_pkg::pix_t pix_s1;
	logic          q_not_full;
	logic          q_not_empty;
	pfc_pkg::pix_t q_head;
	logic          q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_format  <= pfc_pkg::FMT_RGBA8888;
			cfg_q.dst_format  <= pfc_pkg::FMT_RGBA8888;
			cfg_q.premultiply <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfc_pkg::REG_SRC_FORMAT:  cfg_q.src_format  <= cfg_data[2:0];
				pfc_pkg::REG_DST_FORMAT:  cfg_q.dst_format  <= cfg_data[2:0];
				pfc_pkg::REG_PREMULTIPLY: cfg_q.premultiply <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// expand source pixels
	pfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_ch    (in_ch),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1),
		.take     (q_not_full)
	);

	// decouple front from back
	pfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (pix_s1),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// pack, premultiply and present
	pfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.avail  (q_not_empty),
		.head   (q_head),
		.take   (q_pop),
		.out_ch (out_ch)
	);

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for pixel_format_converter: directed, stall and random phases
// depends on pfc_pkg, pfc_if and pixel_format_converter; predicts each converted pixel and checks it in order
module tb_top;

	// register index with no register behind it
	localparam logic [pfc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// format codes with no layout behind them
	localparam logic [2:0] FMT_NONE_6 = 3'd6;
	localparam logic [2:0] FMT_NONE_7 = 3'd7;
	localparam int DRAIN_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int RANDOM_PIXELS = 420;

	typedef struct packed {
		logic [31:0] pixel;
		logic        last;
	} px_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data;

	pfc_in_if  in_ch ();
	pfc_out_if out_ch ();

	pixel_format_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// configuration as the block should hold it
	logic [2:0] cur_src;
	logic [2:0] cur_dst;
	logic       cur_pm;

	px_result_t expected_px[$];
	int         mismatch_count = 0;
	int         idle_cycles;
	bit         src_gaps = 1'b0;
	bit         sink_stalls = 1'b0;
	bit         long_hold_req = 1'b0;
	int         sink_hold;

	initial forever #5 clk = ~clk;

	// expected output word for one source pixel under a given configuration
	function automatic logic [31:0] convert_pixel(logic [31:0] p, logic [2:0] sf,
			logic [2:0] df, logic pm);
		logic [31:0] rgba;
		logic [31:0] res;
		logic [3:0]  a4;
		logic [7:0]  a8;
		logic [7:0]  n0, n1, n2;
		logic [15:0] m0, m1, m2;
		// unpack to rgba8888, narrow channels left-aligned
		case (sf)
			pfc_pkg::FMT_A8:       rgba = {p[7:0], 24'h0};
			pfc_pkg::FMT_RGB888:   rgba = {8'hFF, p[23:0]};
			pfc_pkg::FMT_RGB565:   rgba = {8'hFF, p[4:0], 3'b0, p[10:5], 2'b0,
				p[15:11], 3'b0};
			pfc_pkg::FMT_RGBA5551: rgba = {{8{p[15]}}, p[14:10], 3'b0, p[9:5], 3'b0,
				p[4:0], 3'b0};
			pfc_pkg::FMT_RGBA4444: rgba = {p[3:0], 4'b0, p[7:4], 4'b0, p[11:8], 4'b0,
				p[15:12], 4'b0};
			pfc_pkg::FMT_RGBA8888: rgba = p;
			default:               rgba = 32'h0;
		endcase
		// pack by truncation, 5551 alpha bit as OR of the top alpha nibble
		case (df)
			pfc_pkg::FMT_A8:       res = {24'h0, rgba[31:24]};
			pfc_pkg::FMT_RGB888:   res = {8'h0, rgba[23:0]};
			pfc_pkg::FMT_RGB565:   res = {16'h0, rgba[7:3], rgba[15:10], rgba[23:19]};
			pfc_pkg::FMT_RGBA5551: res = {16'h0, |rgba[31:28], rgba[23:19], rgba[15:11],
				rgba[7:3]};
			pfc_pkg::FMT_RGBA4444: res = {16'h0, rgba[7:4], rgba[15:12], rgba[23:20],
				rgba[31:28]};
			pfc_pkg::FMT_RGBA8888: res = rgba;
			default:               res = 32'h0;
		endcase
		// premultiply in the destination layout
		if (pm) begin
			case (df)
				pfc_pkg::FMT_RGBA5551: begin
					if (!res[15])
						res = 32'h0;
				end
				pfc_pkg::FMT_RGBA4444: begin
					a4 = res[3:0];
					n0 = res[7:4] * a4;
					n1 = res[11:8] * a4;
					n2 = res[15:12] * a4;
					res = {16'h0, n2[7:4], n1[7:4], n0[7:4], a4};
				end
				pfc_pkg::FMT_RGBA8888: begin
					a8 = res[31:24];
					m0 = res[7:0] * a8;
					m1 = res[15:8] * a8;
					m2 = res[23:16] * a8;
					res = {a8, m2[15:8], m1[15:8], m0[15:8]};
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// offer one pixel request and record its expected result once taken
	task automatic send_pixel(logic [31:0] pix, logic last);
		int gap;
		px_result_t exp_item;
		gap = src_gaps ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_in <= pix;
		in_ch.last_in <= last;
		do @(posedge clk); while (!in_ch.ready);
		exp_item.pixel = convert_pixel(pix, cur_src, cur_dst, cur_pm);
		exp_item.last = last;
		expected_px.push_back(exp_item);
	endtask

	// stop offering and wait until the pipeline is empty
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_px.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [pfc_pkg::CFG_IDX_W-1:0] idx,
			logic [pfc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pfc_pkg::REG_SRC_FORMAT:  cur_src = val;
			pfc_pkg::REG_DST_FORMAT:  cur_dst = val;
			pfc_pkg::REG_PREMULTIPLY: cur_pm = val[0];
			default: ;
		endcase
	endtask

	task automatic set_formats(logic [2:0] sf, logic [2:0] df, logic pm);
		settle();
		write_reg(pfc_pkg::REG_SRC_FORMAT, sf);
		write_reg(pfc_pkg::REG_DST_FORMAT, df);
		write_reg(pfc_pkg::REG_PREMULTIPLY, {2'b0, pm});
	endtask

	task automatic run_case(logic [2:0] sf, logic [2:0] df, logic pm, logic [31:0] pix,
			logic last);
		set_formats(sf, df, pm);
		send_pixel(pix, last);
	endtask

	// reset values: rgba8888 straight through, no premultiply
	task automatic test_reset_defaults();
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);
		send_pixel(32'h80FF_017F, 1'b0);
	endtask

	// every layout on both sides, premultiply and the invalid layouts
	task automatic test_format_pairs();
		run_case(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGBA8888, 1'b0, 32'hABCD_F81F, 1'b1);
		run_case(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGBA8888, 1'b0, 32'h0000_FFFF, 1'b0);
		run_case(pfc_pkg::FMT_A8, pfc_pkg::FMT_RGBA8888, 1'b0, 32'hFFFF_FF5A, 1'b1);
		run_case(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_A8, 1'b0, 32'hFF12_3456, 1'b0);
		run_case(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_A8, 1'b0, 32'h9C00_0000, 1'b1);
		run_case(pfc_pkg::FMT_RGBA5551, pfc_pkg::FMT_RGBA4444, 1'b0, 32'h0000_FFFF, 1'b0);
		run_case(pfc_pkg::FMT_RGBA5551, pfc_pkg::FMT_RGBA4444, 1'b0, 32'hFFFF_7FFF, 1'b1);
		run_case(pfc_pkg::FMT_RGBA4444, pfc_pkg::FMT_RGBA5551, 1'b0, 32'h0000_FFF1, 1'b0);
		run_case(pfc_pkg::FMT_RGBA4444, pfc_pkg::FMT_RGBA5551, 1'b0, 32'h0000_FFF0, 1'b1);
		run_case(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_RGBA5551, 1'b1, 32'h0FFF_FFFF, 1'b0);
		run_case(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_RGBA5551, 1'b1, 32'hF0FF_FFFF, 1'b1);
		run_case(pfc_pkg::FMT_RGBA4444, pfc_pkg::FMT_RGBA4444, 1'b1, 32'h0000_FFF8, 1'b0);
		run_case(pfc_pkg::FMT_RGBA4444, pfc_pkg::FMT_RGBA4444, 1'b1, 32'h0000_8F4F, 1'b1);
		run_case(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_RGBA8888, 1'b1, 32'hFFFF_FFFF, 1'b0);
		run_case(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_RGBA8888, 1'b1, 32'h80FF_4001, 1'b1);
		run_case(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_RGB565, 1'b1, 32'h00FF_FFFF, 1'b0);
		// source and destination codes with no layout
		run_case(FMT_NONE_6, pfc_pkg::FMT_RGBA8888, 1'b0, 32'h1234_5678, 1'b1);
		run_case(FMT_NONE_7, pfc_pkg::FMT_RGB888, 1'b0, 32'hFFFF_FFFF, 1'b0);
		run_case(pfc_pkg::FMT_RGBA8888, FMT_NONE_6, 1'b0, 32'hFFFF_FFFF, 1'b1);
		run_case(pfc_pkg::FMT_RGBA8888, FMT_NONE_7, 1'b1, 32'h1234_5678, 1'b0);
	endtask

	// unused index ignored, wide data truncated to the register width
	task automatic test_register_writes();
		set_formats(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_RGBA8888, 1'b1);
		write_reg(REG_UNUSED, 3'b000);
		write_reg(pfc_pkg::REG_PREMULTIPLY, 3'b110);
		send_pixel(32'h8080_8080, 1'b0);
		settle();
		write_reg(REG_UNUSED, 3'b111);
		write_reg(pfc_pkg::REG_PREMULTIPLY, 3'b111);
		send_pixel(32'h8080_8080, 1'b1);
	endtask

	// receiver holds off long enough for the input to back up
	task automatic test_output_backpressure();
		set_formats(pfc_pkg::FMT_RGBA4444, pfc_pkg::FMT_RGBA8888, 1'b1);
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		long_hold_req = 1'b1;
		repeat (40)
			send_pixel($urandom, 1'($urandom_range(0, 1)));
		settle();
	endtask

	// random configurations, random pixels, random idling on both sides
	task automatic test_random_stream();
		int sent;
		int count;
		logic [2:0] sf;
		logic [2:0] df;
		logic [31:0] pix;
		int r;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			sf = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) :
				3'($urandom_range(0, 5));
			df = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) :
				3'($urandom_range(0, 5));
			settle();
			write_reg(pfc_pkg::REG_SRC_FORMAT, sf);
			write_reg(pfc_pkg::REG_DST_FORMAT, df);
			write_reg(pfc_pkg::REG_PREMULTIPLY, 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, 3'($urandom_range(0, 7)));
			src_gaps = ($urandom_range(0, 2) != 0);
			sink_stalls = ($urandom_range(0, 2) != 0);
			count = $urandom_range(20, 60);
			repeat (count) begin
				r = $urandom_range(0, 15);
				if (r == 0)
					pix = 32'h0;
				else if (r == 1)
					pix = 32'hFFFF_FFFF;
				else
					pix = $urandom;
				send_pixel(pix, $urandom_range(0, 7) == 0);
			end
			sent += count;
		end
	endtask

	// receiver ready: steady, random stalls, or one long hold on request
	always begin : sink_ready
		@(negedge clk);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			out_ch.ready <= 1'b0;
			repeat (LONG_HOLD_CYCLES) @(negedge clk);
		end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
			sink_hold = gap_len();
			out_ch.ready <= (sink_hold == 0);
			repeat (sink_hold) @(negedge clk);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// compare each output request with the oldest expectation
	always @(posedge clk) begin
		px_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_px.size() == 0) begin
				$display("%0t: unexpected output pixel %h last %b", $time,
					out_ch.pixel_out, out_ch.last_out);
				mismatch_count++;
			end else begin
				want = expected_px.pop_front();
				if (out_ch.pixel_out !== want.pixel) begin
					$display("%0t: pixel_out expected %h got %h", $time,
						want.pixel, out_ch.pixel_out);
					mismatch_count++;
				end
				if (out_ch.last_out !== want.last) begin
					$display("%0t: last_out expected %b got %b", $time,
						want.last, out_ch.last_out);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog expired", $time);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.pixel_in = 32'h0;
		in_ch.last_in = 1'b0;
		out_ch.ready = 1'b0;
		cur_src = pfc_pkg::FMT_RGBA8888;
		cur_dst = pfc_pkg::FMT_RGBA8888;
		cur_pm = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		sink_stalls = 1'b1;
		test_reset_defaults();
		test_format_pairs();
		test_register_writes();
		test_output_backpressure();
		test_random_stream();
		settle();

		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> files.f
design/pfc_pkg.sv
design/pfc_if.sv
design/pfc_front.sv
design/pfc_queue.sv
design/pfc_back.sv
design/pixel_format_converter.sv
verif/tb_top.sv
